>>> rtl/core/ps2_mouse_packet_event_decoder_top_assert.svh
// assertion macros for the ps2 mouse packet event decoder
`ifndef PS2_MOUSE_PACKET_EVENT_DECODER_TOP_ASSERT_SVH
`define PS2_MOUSE_PACKET_EVENT_DECODER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// property that must hold in every cycle out of reset
`define PS2MD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition in one cycle implies a consequence in the next
`define PS2MD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PS2MD_ASSERT(label, prop, msg)
`define PS2MD_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

>>> rtl/core/ps2md_pkg.sv
// shared types and codes for the ps2 mouse packet event decoder
package ps2md_pkg;

    localparam int BYTE_W  = 8;
    localparam int MOVE_W  = 9;
    localparam int KIND_W  = 3;
    localparam int COUNT_W = 32;
    localparam int POS_W   = 2;
    localparam int MODE_W  = 2;

    // status byte bit positions
    localparam int SYNC_BIT   = 3;
    localparam int LEFT_BIT   = 0;
    localparam int RIGHT_BIT  = 1;
    localparam int MIDDLE_BIT = 2;
    localparam int XSIGN_BIT  = 4;
    localparam int YSIGN_BIT  = 5;
    localparam int XOVF_BIT   = 6;
    localparam int YOVF_BIT   = 7;

    // byte position in packet
    localparam logic [POS_W-1:0] POS_STATUS = 2'd0;
    localparam logic [POS_W-1:0] POS_X      = 2'd1;
    localparam logic [POS_W-1:0] POS_Y      = 2'd2;

    // button tracker states
    localparam logic [MODE_W-1:0] MODE_ALL_REL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LEFT    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RIGHT   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_OTHER   = 2'd3;

    // event kinds
    localparam logic [KIND_W-1:0] EV_MOVE       = 3'd0;
    localparam logic [KIND_W-1:0] EV_LB_PRESS   = 3'd1;
    localparam logic [KIND_W-1:0] EV_LB_RELEASE = 3'd2;
    localparam logic [KIND_W-1:0] EV_RB_PRESS   = 3'd3;
    localparam logic [KIND_W-1:0] EV_RB_RELEASE = 3'd4;
    localparam logic [KIND_W-1:0] EV_OTHER      = 3'd5;

    typedef struct packed {
        logic left;
        logic right;
        logic middle;
    } buttons_t;

endpackage

>>> rtl/core/ps2md_button_tracker.sv
// four-state button tracker that names the event of each packet
module ps2md_button_tracker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  ps2md_pkg::buttons_t           buttons,
    output logic [ps2md_pkg::KIND_W-1:0]  kind,
    output logic [ps2md_pkg::MODE_W-1:0]  mode
);
    import ps2md_pkg::*;

    logic [MODE_W-1:0] mode_reg;
    logic [MODE_W-1:0] mode_next;
    logic              none;
    logic              only_l;
    logic              only_r;

    assign none   = !buttons.left && !buttons.right && !buttons.middle;
    assign only_l = buttons.left && !buttons.right && !buttons.middle;
    assign only_r = buttons.right && !buttons.left && !buttons.middle;

    always_comb
    begin
        mode_next = mode_reg;
        kind      = EV_OTHER;
        case (mode_reg)
            MODE_ALL_REL:
            begin
                if (none)
                begin
                    kind = EV_MOVE;
                end
                else if (only_l)
                begin
                    kind      = EV_LB_PRESS;
                    mode_next = MODE_LEFT;
                end
                else if (only_r)
                begin
                    kind      = EV_RB_PRESS;
                    mode_next = MODE_RIGHT;
                end
                else
                begin
                    mode_next = MODE_OTHER;
                end
            end
            MODE_LEFT:
            begin
                if (none)
                begin
                    kind      = EV_LB_RELEASE;
                    mode_next = MODE_ALL_REL;
                end
                else if (only_l)
                begin
                    kind = EV_MOVE;
                end
                else
                begin
                    mode_next = MODE_OTHER;
                end
            end
            MODE_RIGHT:
            begin
                if (none)
                begin
                    kind      = EV_RB_RELEASE;
                    mode_next = MODE_ALL_REL;
                end
                else if (only_r)
                begin
                    kind = EV_MOVE;
                end
                else
                begin
                    mode_next = MODE_OTHER;
                end
            end
            default:
            begin
                // mixed buttons: always an other event, settle on a clean state
                if (none)
                begin
                    mode_next = MODE_ALL_REL;
                end
                else if (only_r)
                begin
                    mode_next = MODE_RIGHT;
                end
                else if (only_l)
                begin
                    mode_next = MODE_LEFT;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_ALL_REL;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
        end
    end

    assign mode = mode_reg;

endmodule

>>> rtl/core/ps2_mouse_packet_event_decoder_top.sv
// top level of the ps2 mouse three-byte packet event decoder
// path: a taken byte is held in the input register for the decode stage; the third byte of a
//   packet loads the result register, and so out_valid, when it leaves the decode stage
// throughput: one byte per cycle; only a stalled result with a third byte waiting
//   behind it holds the input
// reset: asynchronous active low, clears byte position, held status and x bytes, button state,
//   packet count and both valid flags
module ps2_mouse_packet_event_decoder_top (
    input  logic                                clk,
    input  logic                                rst_n,
    // input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [ps2md_pkg::BYTE_W-1:0]        rx_byte,
    // output channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                left_button,
    output logic                                right_button,
    output logic                                middle_button,
    output logic                                x_overflow,
    output logic                                y_overflow,
    output logic signed [ps2md_pkg::MOVE_W-1:0] move_x,
    output logic signed [ps2md_pkg::MOVE_W-1:0] move_y,
    output logic [ps2md_pkg::KIND_W-1:0]        event_kind,
    output logic [ps2md_pkg::COUNT_W-1:0]       packets_seen,
    output logic [ps2md_pkg::BYTE_W-1:0]        status_byte
);
    import ps2md_pkg::*;

    // input register: one word waiting for the decode stage
    logic              in_valid_reg;
    logic              in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;

    // packet assembly state
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;
    logic [BYTE_W-1:0]  status_reg;
    logic [BYTE_W-1:0]  status_next;
    logic [BYTE_W-1:0]  x_byte_reg;
    logic [BYTE_W-1:0]  x_byte_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    // result register
    logic out_valid_reg;
    logic out_valid_next;

    logic               in_take;      // word accepted on the input channel
    logic               out_free;     // result register can take a new word
    logic               completes;    // word in decode stage is a third byte
    logic               advance;      // decode stage retires its word
    logic               out_load;     // result register loads this cycle
    buttons_t           buttons;
    logic [KIND_W-1:0]  kind;
    logic [MODE_W-1:0]  mode;

    assign out_free  = !out_valid_reg || !out_stall;
    // a position code of three is treated as the third byte
    assign completes = (pos_reg != POS_STATUS) && (pos_reg != POS_X);
    // first and second bytes only touch internal state, so they never wait
    assign advance   = in_valid_reg && (out_free || !completes);
    assign out_load  = advance && completes;

    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    // packet assembly
    always_comb
    begin
        pos_next    = pos_reg;
        status_next = status_reg;
        x_byte_next = x_byte_reg;
        count_next  = count_reg;
        if (advance)
        begin
            case (pos_reg)
                POS_STATUS:
                begin
                    // a first byte without the sync bit is dropped to regain framing
                    if (in_byte_reg[SYNC_BIT])
                    begin
                        status_next = in_byte_reg;
                        pos_next    = POS_X;
                    end
                end
                POS_X:
                begin
                    x_byte_next = in_byte_reg;
                    pos_next    = POS_Y;
                end
                default:
                begin
                    pos_next   = POS_STATUS;
                    count_next = count_reg + COUNT_W'(1);
                end
            endcase
        end
    end

    assign buttons.left   = status_reg[LEFT_BIT];
    assign buttons.right  = status_reg[RIGHT_BIT];
    assign buttons.middle = status_reg[MIDDLE_BIT];

    ps2md_button_tracker u_tracker (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (out_load),
        .buttons (buttons),
        .kind    (kind),
        .mode    (mode)
    );

    // result valid holds while stalled, drops once taken
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= POS_STATUS;
            status_reg    <= '0;
            x_byte_reg    <= '0;
            count_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
            status_reg    <= status_next;
            x_byte_reg    <= x_byte_next;
            count_reg     <= count_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= rx_byte;
        end
        if (out_load)
        begin
            left_button   <= status_reg[LEFT_BIT];
            right_button  <= status_reg[RIGHT_BIT];
            middle_button <= status_reg[MIDDLE_BIT];
            x_overflow    <= status_reg[XOVF_BIT];
            y_overflow    <= status_reg[YOVF_BIT];
            // ninth bit of each delta is its sign from the status byte
            move_x        <= signed'({status_reg[XSIGN_BIT], x_byte_reg});
            move_y        <= signed'({status_reg[YSIGN_BIT], in_byte_reg});
            event_kind    <= kind;
            packets_seen  <= count_next;
            status_byte   <= status_reg;
        end
    end

    assign out_valid = out_valid_reg;

`include "ps2_mouse_packet_event_decoder_top_assert.svh"

    // assembly never reaches the unused position code
    `PS2MD_ASSERT(a_pos_legal, pos_reg != 2'd3, "byte position took the unused code")
    // a loaded result carries the updated packet count
    `PS2MD_ASSERT_NEXT(a_count_match, out_load, packets_seen == count_reg,
        "packet count mismatch")
    // tracker states agree with the buttons of the packet last loaded into the result register
    `PS2MD_ASSERT(a_left_mode,
        (mode != MODE_LEFT) || (left_button && !right_button && !middle_button),
        "left state without only left held")
    `PS2MD_ASSERT(a_right_mode,
        (mode != MODE_RIGHT) || (right_button && !left_button && !middle_button),
        "right state without only right held")

endmodule

>>> tb/tb_ps2_mouse_packet_event_decoder_top.sv
// testbench for the ps2 mouse packet event decoder: directed packets, then random byte streams
`timescale 1ns / 1ps

module tb_ps2_mouse_packet_event_decoder_top;
    import ps2md_pkg::*;

    // cycles with no word accepted on either side before the run is called hung
    localparam int IDLE_LIMIT  = 500;
    localparam int WORD_TARGET = 650;
    localparam int ROW_COUNT   = 8;
    localparam int PRINT_CAP   = 40;

    // one decoded packet as the block should report it
    typedef struct packed {
        logic                       lb;
        logic                       rb;
        logic                       mb;
        logic                       xo;
        logic                       yo;
        logic signed [MOVE_W-1:0]   dx;
        logic signed [MOVE_W-1:0]   dy;
        logic [KIND_W-1:0]          kind;
        logic [COUNT_W-1:0]         count;
        logic [BYTE_W-1:0]          status;
    } mouse_report_t;

    // event kind and deltas typed in by hand for a directed packet
    typedef struct packed {
        logic                       fixed;
        logic [KIND_W-1:0]          kind;
        logic signed [MOVE_W-1:0]   dx;
        logic signed [MOVE_W-1:0]   dy;
    } pinned_t;

    // one directed packet, optionally preceded by a byte the decoder must drop
    typedef struct packed {
        logic                       has_lead;
        logic [BYTE_W-1:0]          lead;
        logic [BYTE_W-1:0]          st;
        logic [BYTE_W-1:0]          xb;
        logic [BYTE_W-1:0]          yb;
        pinned_t                    pin;
    } script_row_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic [BYTE_W-1:0]          rx_byte = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic                       left_button;
    logic                       right_button;
    logic                       middle_button;
    logic                       x_overflow;
    logic                       y_overflow;
    logic signed [MOVE_W-1:0]   move_x;
    logic signed [MOVE_W-1:0]   move_y;
    logic [KIND_W-1:0]          event_kind;
    logic [COUNT_W-1:0]         packets_seen;
    logic [BYTE_W-1:0]          status_byte;

    // predictor state, mirrors the decoder's registers
    logic [POS_W-1:0]           frame_pos = POS_STATUS;
    logic [BYTE_W-1:0]          frame_status = '0;
    logic [BYTE_W-1:0]          frame_x = '0;
    logic [MODE_W-1:0]          track_mode = MODE_ALL_REL;
    logic [COUNT_W-1:0]         frame_count = '0;

    mouse_report_t              expected_reports[$];
    pinned_t                    pinned_q[$];
    script_row_t                script [ROW_COUNT];

    int                         mismatch_count = 0;
    int                         idle_cycles = 0;
    int                         words_sent = 0;
    int                         burst_left = 0;
    int                         stall_tick = 0;
    int                         stall_mode = 0;

    ps2_mouse_packet_event_decoder_top uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .left_button    (left_button),
        .right_button   (right_button),
        .middle_button  (middle_button),
        .x_overflow     (x_overflow),
        .y_overflow     (y_overflow),
        .move_x         (move_x),
        .move_y         (move_y),
        .event_kind     (event_kind),
        .packets_seen   (packets_seen),
        .status_byte    (status_byte)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // one line per mismatch, printing capped so a broken build stays readable
    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatch_count < PRINT_CAP)
            $display("%0t mismatch %s: got %0d, want %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_field(input string what, input longint got, input longint want);
        if (got != want)
            report_mismatch(what, got, want);
    endtask

    // advance the predictor by one accepted byte; a completed packet queues a report
    task automatic predict_byte(input logic [BYTE_W-1:0] b);
        mouse_report_t r;
        pinned_t       pin;
        logic          none;
        logic          only_l;
        logic          only_r;
        case (frame_pos)
            POS_STATUS:
            begin
                // resync: a first byte without the always-one bit is thrown away
                if (b[SYNC_BIT])
                begin
                    frame_status = b;
                    frame_pos = POS_X;
                end
            end
            POS_X:
            begin
                frame_x = b;
                frame_pos = POS_Y;
            end
            default:
            begin
                frame_pos = POS_STATUS;
                frame_count = frame_count + 1'b1;
                r.lb = frame_status[LEFT_BIT];
                r.rb = frame_status[RIGHT_BIT];
                r.mb = frame_status[MIDDLE_BIT];
                r.xo = frame_status[XOVF_BIT];
                r.yo = frame_status[YOVF_BIT];
                // ninth bit of each delta lives in the status byte
                r.dx = {frame_status[XSIGN_BIT], frame_x};
                r.dy = {frame_status[YSIGN_BIT], b};
                r.count = frame_count;
                r.status = frame_status;
                none = !r.lb && !r.rb && !r.mb;
                only_l = r.lb && !r.rb && !r.mb;
                only_r = r.rb && !r.lb && !r.mb;
                // button tracker
                case (track_mode)
                    MODE_ALL_REL:
                    begin
                        if (none)
                            r.kind = EV_MOVE;
                        else if (only_l)
                        begin
                            r.kind = EV_LB_PRESS;
                            track_mode = MODE_LEFT;
                        end
                        else if (only_r)
                        begin
                            r.kind = EV_RB_PRESS;
                            track_mode = MODE_RIGHT;
                        end
                        else
                        begin
                            r.kind = EV_OTHER;
                            track_mode = MODE_OTHER;
                        end
                    end
                    MODE_LEFT:
                    begin
                        if (none)
                        begin
                            r.kind = EV_LB_RELEASE;
                            track_mode = MODE_ALL_REL;
                        end
                        else if (only_l)
                            r.kind = EV_MOVE;
                        else
                        begin
                            r.kind = EV_OTHER;
                            track_mode = MODE_OTHER;
                        end
                    end
                    MODE_RIGHT:
                    begin
                        if (none)
                        begin
                            r.kind = EV_RB_RELEASE;
                            track_mode = MODE_ALL_REL;
                        end
                        else if (only_r)
                            r.kind = EV_MOVE;
                        else
                        begin
                            r.kind = EV_OTHER;
                            track_mode = MODE_OTHER;
                        end
                    end
                    default:
                    begin
                        // mixed buttons always report as other, then settle
                        r.kind = EV_OTHER;
                        if (none)
                            track_mode = MODE_ALL_REL;
                        else if (only_r)
                            track_mode = MODE_RIGHT;
                        else if (only_l)
                            track_mode = MODE_LEFT;
                    end
                endcase
                // directed packets may carry hand-written kind and deltas
                if (pinned_q.size() > 0)
                begin
                    pin = pinned_q.pop_front();
                    if (pin.fixed)
                    begin
                        r.kind = pin.kind;
                        r.dx = pin.dx;
                        r.dy = pin.dy;
                    end
                end
                expected_reports.push_back(r);
            end
        endcase
    endtask

    // compare one accepted result word with the oldest expected report
    task automatic check_report();
        mouse_report_t want;
        if (expected_reports.size() == 0)
        begin
            report_mismatch("report with none expected, packets_seen", packets_seen, 0);
        end
        else
        begin
            want = expected_reports.pop_front();
            check_field("left_button", left_button, want.lb);
            check_field("right_button", right_button, want.rb);
            check_field("middle_button", middle_button, want.mb);
            check_field("x_overflow", x_overflow, want.xo);
            check_field("y_overflow", y_overflow, want.yo);
            check_field("move_x", move_x, $signed(want.dx));
            check_field("move_y", move_y, $signed(want.dy));
            check_field("event_kind", event_kind, want.kind);
            check_field("packets_seen", packets_seen, want.count);
            check_field("status_byte", status_byte, want.status);
        end
    endtask

    // monitor: sample both handshakes at the edge, before the block updates
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                predict_byte(rx_byte);
            if (out_valid && !out_stall)
                check_report();
            // watchdog on progress
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t watchdog: no word moved for %0d cycles", $realtime, IDLE_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // receiver back-pressure: a new pattern is picked each time the stall tick wraps to zero,
    //   free flowing, coin flip, stalled unless the tick modulo four is three, or a stall then free
    always @(posedge clk)
    begin
        stall_tick = (stall_tick + 1) % 48;
        if (stall_tick == 0)
            stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= 1'($urandom_range(0, 1));
            2: out_stall <= (stall_tick % 4) != 3;
            default: out_stall <= stall_tick < 20;
        endcase
    end

    // send one word; bursts of random length separated by random gaps
    task automatic send_word(input logic [BYTE_W-1:0] b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                // junk on the bus while not valid, must be ignored
                in_valid <= 1'b0;
                rx_byte <= 8'($urandom);
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
    endtask

    // stop sending until every expected report has come out
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (expected_reports.size() != 0);
    endtask

    // mostly well-formed packets with random content, some stray and dropped bytes
    task automatic send_random_packet();
        int                 pick;
        logic [BYTE_W-1:0]  st;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            send_word(8'($urandom) & ~(8'h1 << SYNC_BIT));
        else if (pick < 12)
            send_word(8'($urandom));
        st = 8'($urandom);
        st[SYNC_BIT] = 1'b1;
        // bias buttons toward no button or a single button so the tracker moves around
        pick = $urandom_range(0, 9);
        if (pick < 4)
            st[2:0] = 3'b000;
        else if (pick < 6)
            st[2:0] = 3'b001;
        else if (pick < 8)
            st[2:0] = 3'b010;
        send_word(st);
        send_word(8'($urandom));
        send_word(8'($urandom));
    endtask

    initial
    begin
        bit paused_once;
        paused_once = 1'b0;

        // directed packets: lead, status, x, y, then pinned kind and deltas where obvious
        //   dropped zero lead, then a bare move after reset
        script[0] = {1'b1, 8'h00, 8'h08, 8'h00, 8'h00, 1'b1, EV_MOVE, 9'h000, 9'h000};
        //   left press, largest positive x
        script[1] = {1'b0, 8'h00, 8'h09, 8'hFF, 8'h01, 1'b1, EV_LB_PRESS, 9'h0FF, 9'h001};
        //   left release, both deltas at -256, x byte has the sync bit clear
        script[2] = {1'b0, 8'h00, 8'h38, 8'h00, 8'h00, 1'b1, EV_LB_RELEASE, 9'h100, 9'h100};
        //   right press
        script[3] = {1'b0, 8'h00, 8'h0A, 8'h80, 8'h7F, 1'b1, EV_RB_PRESS, 9'h080, 9'h07F};
        //   right still held is a move, deltas -1
        script[4] = {1'b0, 8'h00, 8'h3A, 8'hFF, 8'hFF, 1'b1, EV_MOVE, 9'h1FF, 9'h1FF};
        //   right release with both overflow flags
        script[5] = {1'b0, 8'h00, 8'hC8, 8'h55, 8'hAA, 1'b1, EV_RB_RELEASE, 9'h055, 9'h0AA};
        //   dropped lead with every other bit set, then all buttons: other, deltas still carried
        script[6] = {1'b1, 8'hF7, 8'hFF, 8'h01, 8'h02, 1'b1, EV_OTHER, 9'h101, 9'h102};
        //   middle only from the mixed state stays other
        script[7] = {1'b0, 8'h00, 8'h0C, 8'h04, 8'hF0, 1'b0, EV_MOVE, 9'h000, 9'h000};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < ROW_COUNT; i++)
        begin
            pinned_q.push_back(script[i].pin);
            if (script[i].has_lead)
                send_word(script[i].lead);
            send_word(script[i].st);
            send_word(script[i].xb);
            send_word(script[i].yb);
        end
        hold_until_drained();

        // random stream, with one more full drain halfway through
        while (words_sent < WORD_TARGET)
        begin
            send_random_packet();
            if (!paused_once && words_sent >= WORD_TARGET / 2)
            begin
                hold_until_drained();
                paused_once = 1'b1;
            end
        end

        // drain, then keep running to catch any stray report
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_reports.size() != 0);
        repeat (8) @(posedge clk);

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
